[design/bwl_pkg.sv]
package bwl_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int LEVEL_W    = 12;
  localparam int RECOVER_W  = 18;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [RECOVER_W-1:0] COUNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLD_RUN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLBACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLBACK_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd7;

  // Register reset values
  localparam logic [LEVEL_W-1:0]   RST_COLD_RUN   = 12'd2600;
  localparam logic [LEVEL_W-1:0]   RST_LOW        = 12'd2200;
  localparam logic [LEVEL_W-1:0]   RST_MAX        = 12'd3600;
  localparam logic [LEVEL_W-1:0]   RST_ROLLBACK   = 12'd2500;
  localparam logic [LEVEL_W-1:0]   RST_ROLLBACK_H = 12'd3400;
  localparam logic [LEVEL_W-1:0]   RST_WARN       = 12'd2400;
  localparam logic [RECOVER_W-1:0] RST_RECOVER    = 18'd10000;
  localparam logic [HOLD_W-1:0]    RST_HOLD       = 16'd3000;

  // Phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_COLD  = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_HOLD  = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0]   cold_run_level;
    logic [LEVEL_W-1:0]   low_level;
    logic [LEVEL_W-1:0]   max_level;
    logic [LEVEL_W-1:0]   rollback_level;
    logic [LEVEL_W-1:0]   rollback_high_level;
    logic [LEVEL_W-1:0]   warn_level;
    logic [RECOVER_W-1:0] recover_ticks;
    logic [HOLD_W-1:0]    hold_ticks;
  } bwl_cfg_t;

  typedef struct packed {
    logic locked_out;
    logic low_warning;
    logic very_low_relay;
    logic relay_changed;
  } bwl_result_t;

endpackage

[design/battery_window_lockout.sv]
// Battery window lockout.
// Input channel: in_valid/in_ready carry one battery_sample per request
// (one per 1 ms tick in the application). Result channel: out_valid/out_ready
// carry exactly one result per input request: locked_out, low_warning,
// very_low_relay and relay_changed, in input order.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no request is in flight.
// A request accepted on the input channel passes the input register, then
// the result register, before it is offered on the result channel.
// Throughput: one request per cycle while out_ready stays high, set by
// the single combinational step between the input and result registers.
// Reset (synchronous, rst_n low): registers return to their defaults, the
// lockout is set, the startup hold restarts and both channels empty.
// Receiver stall: the result register holds its request, the input register
// takes one more request, then in_ready drops until out_ready returns.
module battery_window_lockout
  import bwl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_battery_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_locked_out,
  output logic                   out_low_warning,
  output logic                   out_very_low_relay,
  output logic                   out_relay_changed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  bwl_cfg_t    cfg;
  bwl_result_t step_result;

  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   out_valid_r;
  bwl_result_t            result_r;
  logic                   advance;

  assign cfg_ready = 1'b1;
  // Advance when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  bwl_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bwl_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .sample (sample_r),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)
        in_valid_r <= in_valid;
      if (advance)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      sample_r <= in_battery_sample;
    if (advance)
      result_r <= step_result;
  end

  assign out_valid          = out_valid_r;
  assign out_locked_out     = result_r.locked_out;
  assign out_low_warning    = result_r.low_warning;
  assign out_very_low_relay = result_r.very_low_relay;
  assign out_relay_changed  = result_r.relay_changed;

endmodule

[design/bwl_regs.sv]
module bwl_regs
  import bwl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output bwl_cfg_t              cfg
);

  bwl_cfg_t cfg_r;
  bwl_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_COLD_RUN:   cfg_nxt.cold_run_level      = wr_data[LEVEL_W-1:0];
        REG_LOW:        cfg_nxt.low_level           = wr_data[LEVEL_W-1:0];
        REG_MAX:        cfg_nxt.max_level           = wr_data[LEVEL_W-1:0];
        REG_ROLLBACK:   cfg_nxt.rollback_level      = wr_data[LEVEL_W-1:0];
        REG_ROLLBACK_H: cfg_nxt.rollback_high_level = wr_data[LEVEL_W-1:0];
        REG_WARN:       cfg_nxt.warn_level          = wr_data[LEVEL_W-1:0];
        REG_RECOVER:    cfg_nxt.recover_ticks       = wr_data[RECOVER_W-1:0];
        REG_HOLD:       cfg_nxt.hold_ticks          = wr_data[HOLD_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cold_run_level      <= RST_COLD_RUN;
      cfg_r.low_level           <= RST_LOW;
      cfg_r.max_level           <= RST_MAX;
      cfg_r.rollback_level      <= RST_ROLLBACK;
      cfg_r.rollback_high_level <= RST_ROLLBACK_H;
      cfg_r.warn_level          <= RST_WARN;
      cfg_r.recover_ticks       <= RST_RECOVER;
      cfg_r.hold_ticks          <= RST_HOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/bwl_core.sv]
module bwl_core
  import bwl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  bwl_cfg_t               cfg,
  output bwl_result_t            result
);

  localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  logic [1:0]           phase_r, phase_nxt;
  logic [HOLD_W-1:0]    hold_count_r, hold_count_nxt;
  logic                 blocked_r, blocked_nxt;
  logic                 recovering_r, recovering_nxt;
  logic [RECOVER_W-1:0] recovery_count_r, recovery_count_nxt;
  logic                 warn_flag_r, warn_flag_nxt;
  logic                 relay_flag_r, relay_flag_nxt;

  logic [CMP_W-1:0] s;
  logic             busy;
  logic             trigger;
  logic             in_window;

  always_comb begin
    s                  = CMP_W'(sample);
    phase_nxt          = phase_r;
    hold_count_nxt     = hold_count_r;
    blocked_nxt        = blocked_r;
    recovering_nxt     = recovering_r;
    recovery_count_nxt = recovery_count_r;
    warn_flag_nxt      = warn_flag_r;
    relay_flag_nxt     = relay_flag_r;
    busy               = 1'b0;
    trigger            = 1'b0;
    in_window          = 1'b0;

    // Hold phases: count off the tick, or fall through to the next phase
    if (phase_r == PH_START || phase_r == PH_HOLD) begin
      if (hold_count_r < cfg.hold_ticks) begin
        hold_count_nxt = hold_count_r + 1'b1;
        if (phase_r == PH_HOLD && recovering_r && recovery_count_r != COUNT_MAX)
          recovery_count_nxt = recovery_count_r + 1'b1;
        busy = 1'b1;
      end else begin
        phase_nxt = (phase_r == PH_START) ? PH_COLD : PH_RUN;
      end
    end

    if (!busy && phase_nxt == PH_COLD) begin
      if (s >= CMP_W'(cfg.cold_run_level)) begin
        blocked_nxt    = 1'b0;
        relay_flag_nxt = 1'b0;
        phase_nxt      = PH_RUN;
      end else begin
        blocked_nxt = 1'b1;
      end
    end

    if (!busy && phase_nxt == PH_RUN) begin
      if (!blocked_nxt && (s <= CMP_W'(cfg.low_level) || s >= CMP_W'(cfg.max_level))) begin
        blocked_nxt        = 1'b1;
        recovering_nxt     = 1'b0;
        recovery_count_nxt = '0;
        trigger            = 1'b1;
      end
      in_window = s >= CMP_W'(cfg.rollback_level) && s <= CMP_W'(cfg.rollback_high_level);
      if (blocked_nxt && in_window) begin
        if (!recovering_nxt) begin
          recovering_nxt     = 1'b1;
          recovery_count_nxt = '0;
        end else if (recovery_count_nxt != COUNT_MAX) begin
          recovery_count_nxt = recovery_count_nxt + 1'b1;
        end
        if (recovery_count_nxt > cfg.recover_ticks) begin
          blocked_nxt        = 1'b0;
          recovering_nxt     = 1'b0;
          recovery_count_nxt = '0;
        end
      end else begin
        recovering_nxt     = 1'b0;
        recovery_count_nxt = '0;
      end
      warn_flag_nxt  = !blocked_nxt && s <= CMP_W'(cfg.warn_level);
      relay_flag_nxt = blocked_nxt;
      if (trigger) begin
        phase_nxt      = PH_HOLD;
        hold_count_nxt = '0;
      end
    end

    result.locked_out     = blocked_nxt;
    result.low_warning    = warn_flag_nxt;
    result.very_low_relay = relay_flag_nxt;
    result.relay_changed  = (warn_flag_nxt != warn_flag_r) || (relay_flag_nxt != relay_flag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_START;
      hold_count_r     <= '0;
      blocked_r        <= 1'b1;
      recovering_r     <= 1'b0;
      recovery_count_r <= '0;
      warn_flag_r      <= 1'b0;
      relay_flag_r     <= 1'b1;
    end else if (step) begin
      phase_r          <= phase_nxt;
      hold_count_r     <= hold_count_nxt;
      blocked_r        <= blocked_nxt;
      recovering_r     <= recovering_nxt;
      recovery_count_r <= recovery_count_nxt;
      warn_flag_r      <= warn_flag_nxt;
      relay_flag_r     <= relay_flag_nxt;
    end
  end

endmodule

[sim/battery_window_lockout_test.sv]
module battery_window_lockout_test;
  import bwl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 10;
  localparam int          SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned HOLDOFF_LEN  = 80;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [SAMPLE_W-1:0]     smp;
    bwl_result_t             flags;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_battery_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_locked_out;
  logic                  out_low_warning;
  logic                  out_very_low_relay;
  logic                  out_relay_changed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted block state and register copy
  bwl_cfg_t              lk_cfg;
  logic [1:0]            lk_phase;
  logic [HOLD_W-1:0]     lk_hold_cnt;
  logic                  lk_blocked;
  logic                  lk_recovering;
  logic [RECOVER_W-1:0]  lk_recover_cnt;
  logic                  lk_warn;
  logic                  lk_relay;

  bwl_result_t           expected_flags_q[$];
  bwl_result_t           want;
  stim_row_t             directed_rows[$];

  int unsigned fail_count = 0;
  int unsigned results_checked = 0;
  int unsigned relay_changes = 0;
  int unsigned samples_sent = 0;
  int unsigned regs_written = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned holdoff_asks = 0;
  int unsigned holdoff_served = 0;
  int unsigned rx_hold_left = 0;

  battery_window_lockout #(.SAMPLE_BITS(SAMPLE_W)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_battery_sample (in_battery_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_locked_out    (out_locked_out),
    .out_low_warning   (out_low_warning),
    .out_very_low_relay(out_very_low_relay),
    .out_relay_changed (out_relay_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void lockout_reset();
    lk_cfg.cold_run_level      = RST_COLD_RUN;
    lk_cfg.low_level           = RST_LOW;
    lk_cfg.max_level           = RST_MAX;
    lk_cfg.rollback_level      = RST_ROLLBACK;
    lk_cfg.rollback_high_level = RST_ROLLBACK_H;
    lk_cfg.warn_level          = RST_WARN;
    lk_cfg.recover_ticks       = RST_RECOVER;
    lk_cfg.hold_ticks          = RST_HOLD;
    lk_phase       = PH_START;
    lk_hold_cnt    = '0;
    lk_blocked     = 1'b1;
    lk_recovering  = 1'b0;
    lk_recover_cnt = '0;
    lk_warn        = 1'b0;
    lk_relay       = 1'b1;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COLD_RUN:   lk_cfg.cold_run_level      = data[LEVEL_W-1:0];
      REG_LOW:        lk_cfg.low_level           = data[LEVEL_W-1:0];
      REG_MAX:        lk_cfg.max_level           = data[LEVEL_W-1:0];
      REG_ROLLBACK:   lk_cfg.rollback_level      = data[LEVEL_W-1:0];
      REG_ROLLBACK_H: lk_cfg.rollback_high_level = data[LEVEL_W-1:0];
      REG_WARN:       lk_cfg.warn_level          = data[LEVEL_W-1:0];
      REG_RECOVER:    lk_cfg.recover_ticks       = data[RECOVER_W-1:0];
      REG_HOLD:       lk_cfg.hold_ticks          = data[HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bwl_result_t lockout_step(input logic [SAMPLE_W-1:0] s);
    bwl_result_t r;
    logic        prev_warn;
    logic        prev_relay;
    logic        held;
    logic        trig;
    prev_warn  = lk_warn;
    prev_relay = lk_relay;
    held       = 1'b0;
    trig       = 1'b0;
    if (lk_phase == PH_START || lk_phase == PH_HOLD) begin
      if (lk_hold_cnt < lk_cfg.hold_ticks) begin
        lk_hold_cnt = lk_hold_cnt + 1'b1;
        // a window run started on the trigger sample keeps counting
        if (lk_phase == PH_HOLD && lk_recovering && lk_recover_cnt != COUNT_MAX)
          lk_recover_cnt = lk_recover_cnt + 1'b1;
        held = 1'b1;
      end else begin
        lk_phase = (lk_phase == PH_START) ? PH_COLD : PH_RUN;
      end
    end
    if (!held && lk_phase == PH_COLD) begin
      if (s >= lk_cfg.cold_run_level) begin
        lk_blocked = 1'b0;
        lk_relay   = 1'b0;
        lk_phase   = PH_RUN;
      end else begin
        lk_blocked = 1'b1;
      end
    end
    if (!held && lk_phase == PH_RUN) begin
      if (!lk_blocked && (s <= lk_cfg.low_level || s >= lk_cfg.max_level)) begin
        lk_blocked     = 1'b1;
        lk_recovering  = 1'b0;
        lk_recover_cnt = '0;
        trig           = 1'b1;
      end
      if (lk_blocked && s >= lk_cfg.rollback_level && s <= lk_cfg.rollback_high_level) begin
        if (!lk_recovering) begin
          lk_recovering  = 1'b1;
          lk_recover_cnt = '0;
        end else if (lk_recover_cnt != COUNT_MAX) begin
          lk_recover_cnt = lk_recover_cnt + 1'b1;
        end
        if (lk_recover_cnt > lk_cfg.recover_ticks) begin
          lk_blocked     = 1'b0;
          lk_recovering  = 1'b0;
          lk_recover_cnt = '0;
        end
      end else begin
        lk_recovering  = 1'b0;
        lk_recover_cnt = '0;
      end
      lk_warn  = !lk_blocked && s <= lk_cfg.warn_level;
      lk_relay = lk_blocked;
      if (trig) begin
        lk_phase    = PH_HOLD;
        lk_hold_cnt = '0;
      end
    end
    r.locked_out     = lk_blocked;
    r.low_warning    = lk_warn;
    r.very_low_relay = lk_relay;
    r.relay_changed  = (prev_warn != lk_warn) || (prev_relay != lk_relay);
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick(input int unsigned lo, input int unsigned hi);
    return LEVEL_W'($urandom_range(hi, lo));
  endfunction

  function automatic bwl_cfg_t random_cfg(input int unsigned ph);
    bwl_cfg_t c;
    c.low_level           = pick(1500, 2400);
    c.warn_level          = pick(c.low_level, c.low_level + 300);
    c.rollback_level      = pick(c.low_level - 200, c.low_level + 400);
    c.rollback_high_level = pick(2800, 3500);
    c.max_level           = pick(3300, 3900);
    c.cold_run_level      = pick(2300, 3000);
    c.recover_ticks       = RECOVER_W'($urandom_range(24));
    c.hold_ticks          = HOLD_W'($urandom_range(12));
    if (ph == 2) begin
      c.cold_run_level      = '0;
      c.low_level           = '0;
      c.max_level           = '1;
      c.rollback_level      = '0;
      c.rollback_high_level = '1;
      c.warn_level          = '1;
    end else if (ph == 5) begin
      // inverted window and the longest hold
      c.cold_run_level      = '1;
      c.rollback_level      = 12'd3400;
      c.rollback_high_level = 12'd2500;
      c.warn_level          = '0;
      c.hold_ticks          = '1;
    end else if (ph == 7) begin
      c.recover_ticks = '0;
      c.hold_ticks    = '0;
    end
    return c;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = data;
    r.smp   = '0;
    r.flags = '0;
    return r;
  endfunction

  function automatic stim_row_t smp_row(input logic [SAMPLE_W-1:0] s);
    stim_row_t r;
    r       = cfg_row(REG_COLD_RUN, '0);
    r.kind  = ROW_SAMPLE;
    r.smp   = s;
    return r;
  endfunction

  // flags: {locked_out, low_warning, very_low_relay, relay_changed}
  function automatic stim_row_t chk_row(input logic [SAMPLE_W-1:0] s, input logic [3:0] flags);
    stim_row_t r;
    r       = smp_row(s);
    r.kind  = ROW_CHECKED;
    r.flags = bwl_result_t'(flags);
    return r;
  endfunction

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result side: check, then decide the ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (out_relay_changed)
        relay_changes++;
      if (expected_flags_q.size() == 0) begin
        $error("result arrived with no request pending");
        fail_count++;
      end else begin
        want = expected_flags_q.pop_front();
        check_field("locked_out", want.locked_out, out_locked_out);
        check_field("low_warning", want.low_warning, out_low_warning);
        check_field("very_low_relay", want.very_low_relay, out_very_low_relay);
        check_field("relay_changed", want.relay_changed, out_relay_changed);
      end
    end
    if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (holdoff_served != holdoff_asks) begin
      holdoff_served <= holdoff_asks;
      rx_hold_left   <= HOLDOFF_LEN;
      out_ready      <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input bwl_result_t typed_flags);
    bwl_result_t r;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_battery_sample <= smp;
    do @(posedge clk); while (!in_ready);
    r = lockout_step(smp);
    expected_flags_q.push_back(typed ? typed_flags : r);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, data);
    regs_written++;
  endtask

  // Hold the input until every pending request has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_flags_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Upper data bits are junk on narrow registers; the block must drop them
  task automatic apply_cfg(input bwl_cfg_t c);
    write_reg(REG_COLD_RUN, {6'($urandom), c.cold_run_level});
    write_reg(REG_LOW, {6'($urandom), c.low_level});
    write_reg(REG_MAX, {6'($urandom), c.max_level});
    write_reg(REG_ROLLBACK, {6'($urandom), c.rollback_level});
    write_reg(REG_ROLLBACK_H, {6'($urandom), c.rollback_high_level});
    write_reg(REG_WARN, {6'($urandom), c.warn_level});
    write_reg(REG_RECOVER, c.recover_ticks);
    write_reg(REG_HOLD, {2'($urandom), c.hold_ticks});
  endtask

  initial begin : stimulus
    int unsigned         ph;
    int unsigned         k;
    int unsigned         burst;
    int unsigned         kind;
    int                  v;
    logic [SAMPLE_W-1:0] smp;
    logic [LEVEL_W-1:0]  lo;
    logic [LEVEL_W-1:0]  hi;
    logic [LEVEL_W-1:0]  thr;

    lockout_reset();

    // startup hold at reset defaults, then cold wait and its exit
    directed_rows.push_back(chk_row(12'd0, 4'b1010));
    directed_rows.push_back(chk_row(12'd4095, 4'b1010));
    directed_rows.push_back(cfg_row(REG_HOLD, 18'd2));
    directed_rows.push_back(cfg_row(REG_RECOVER, 18'd3));
    directed_rows.push_back(chk_row(12'd0, 4'b1010));
    directed_rows.push_back(chk_row(12'd2599, 4'b1010));
    directed_rows.push_back(chk_row(12'd2600, 4'b0001));
    // warning edges, low trigger, hold, window recovery
    directed_rows.push_back(smp_row(12'd2400));
    directed_rows.push_back(smp_row(12'd2401));
    directed_rows.push_back(smp_row(12'd2201));
    directed_rows.push_back(chk_row(12'd2200, 4'b1011));
    directed_rows.push_back(smp_row(12'd3000));
    directed_rows.push_back(smp_row(12'd3000));
    directed_rows.push_back(smp_row(12'd3000));
    directed_rows.push_back(smp_row(12'd2500));
    directed_rows.push_back(smp_row(12'd3400));
    directed_rows.push_back(smp_row(12'd3000));
    directed_rows.push_back(smp_row(12'd3000));
    // max trigger, then extremes during the hold and after it
    directed_rows.push_back(chk_row(12'd3600, 4'b1011));
    directed_rows.push_back(smp_row(12'd4095));
    directed_rows.push_back(smp_row(12'd0));
    directed_rows.push_back(smp_row(12'd4095));
    // no hold, zero recovery ticks, trigger inside the window
    directed_rows.push_back(cfg_row(REG_HOLD, 18'd0));
    directed_rows.push_back(cfg_row(REG_RECOVER, 18'd0));
    directed_rows.push_back(cfg_row(REG_LOW, 18'd2600));
    directed_rows.push_back(cfg_row(REG_WARN, 18'd4095));
    directed_rows.push_back(smp_row(12'd3000));
    directed_rows.push_back(chk_row(12'd3000, 4'b0101));
    directed_rows.push_back(chk_row(12'd2550, 4'b1011));
    directed_rows.push_back(chk_row(12'd2550, 4'b0101));
    // recovery count advancing through the post-lockout hold
    directed_rows.push_back(cfg_row(REG_HOLD, 18'd3));
    directed_rows.push_back(cfg_row(REG_RECOVER, 18'd4));
    directed_rows.push_back(chk_row(12'd2550, 4'b1011));
    directed_rows.push_back(smp_row(12'd0));
    directed_rows.push_back(smp_row(12'd0));
    directed_rows.push_back(smp_row(12'd0));
    directed_rows.push_back(smp_row(12'd3000));
    directed_rows.push_back(chk_row(12'd3000, 4'b0101));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CFG)
          wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        push_sample(directed_rows[i].smp, directed_rows[i].kind == ROW_CHECKED,
                    directed_rows[i].flags);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      apply_cfg(random_cfg(ph));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      k = 0;
      while (k < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          // window run of up to recover_ticks + 6 samples, which can clear a lockout
          burst = $urandom_range(int'(lk_cfg.recover_ticks) + 6, 1);
          lo = (lk_cfg.rollback_level < lk_cfg.rollback_high_level) ?
               lk_cfg.rollback_level : lk_cfg.rollback_high_level;
          hi = (lk_cfg.rollback_level < lk_cfg.rollback_high_level) ?
               lk_cfg.rollback_high_level : lk_cfg.rollback_level;
        end else begin
          burst = $urandom_range(6, 1);
        end
        while (burst != 0 && k < PHASE_ITEMS) begin
          if (kind < 45) begin
            smp = SAMPLE_W'($urandom_range(hi, lo));
          end else if (kind < 75) begin
            case ($urandom_range(5))
              0: thr = lk_cfg.cold_run_level;
              1: thr = lk_cfg.low_level;
              2: thr = lk_cfg.max_level;
              3: thr = lk_cfg.rollback_level;
              4: thr = lk_cfg.rollback_high_level;
              default: thr = lk_cfg.warn_level;
            endcase
            v = int'(thr) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            smp = SAMPLE_W'(v);
          end else begin
            smp = SAMPLE_W'($urandom_range(4095));
          end
          push_sample(smp, 1'b0, '0);
          k++;
          burst--;
          if (k == PHASE_ITEMS / 2) begin
            // phase 0: stall the result side while requests keep coming; phase 4: drain
            if (ph == 0)
              holdoff_asks++;
            if (ph == 4)
              wait_idle();
          end
        end
      end
    end

    wait_idle();
    $display("Sent %0d samples over %0d register writes across %0d random phases",
             samples_sent, regs_written, PHASES);
    $display("Checked %0d results, %0d of them with a relay change",
             results_checked, relay_changes);
    if (fail_count == 0 && expected_flags_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bwl_pkg.sv
design/bwl_regs.sv
design/bwl_core.sv
design/battery_window_lockout.sv
sim/battery_window_lockout_test.sv
